@@ design/gbp_pkg.sv @@
package gbp_pkg;

   localparam int unsigned ADDR_W = 64;

   localparam logic CMD_PREDICT = 1'b0;
   localparam logic CMD_UPDATE  = 1'b1;

   localparam logic [ADDR_W-1:0] PC_STEP = 64'd4;

   localparam logic [1:0] CTR_MIN   = 2'd0;
   localparam logic [1:0] CTR_TAKEN = 2'd2;
   localparam logic [1:0] CTR_MAX   = 2'd3;
   localparam logic [1:0] CTR_STEP  = 2'd1;

   typedef struct packed {
      logic              valid;
      logic              cond;
      logic [ADDR_W-1:0] tag;
      logic [ADDR_W-1:0] target;
   } btb_entry_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_update;
      logic rsp_free;
   } dp_status_type;

endpackage

@@ design/gbp_ctrl.sv @@
module gbp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  gbp_pkg::dp_status_type status,
   output gbp_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd.clear  = (state_ff == ST_CLEAR);
      cmd.accept = (state_ff == ST_IDLE) && req_valid;
      cmd.finish = (state_ff == ST_LOOKUP) && (status.is_update || status.rsp_free);
      req_ready  = (state_ff == ST_IDLE);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (cmd.finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/gbp_datapath.sv @@
module gbp_datapath #(
   parameter int unsigned HISTORY_BITS   = 8,
   parameter int unsigned BTB_INDEX_BITS = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  gbp_pkg::ctrl_cmd_type       cmd,
   output gbp_pkg::dp_status_type      status,
   input  logic                        req_cmd,
   input  logic [gbp_pkg::ADDR_W-1:0]  req_pc,
   input  logic [gbp_pkg::ADDR_W-1:0]  req_target,
   input  logic                        req_taken,
   input  logic                        req_is_cond,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [gbp_pkg::ADDR_W-1:0]  rsp_next_pc,
   output logic                        rsp_btb_hit,
   output logic                        rsp_predict_taken
);

   localparam int unsigned CLR_BITS  = (HISTORY_BITS > BTB_INDEX_BITS) ?
                                       HISTORY_BITS : BTB_INDEX_BITS;
   localparam int unsigned BTB_DEPTH = 2 ** BTB_INDEX_BITS;
   localparam int unsigned PHT_DEPTH = 2 ** HISTORY_BITS;

   gbp_pkg::btb_entry_type btb_mem [BTB_DEPTH];
   logic [1:0]             pht_mem [PHT_DEPTH];

   logic                        cmd_ff;
   logic [gbp_pkg::ADDR_W-1:0]  pc_ff;
   logic [gbp_pkg::ADDR_W-1:0]  target_ff;
   logic                        taken_ff;
   logic                        is_cond_ff;
   logic [BTB_INDEX_BITS-1:0]   btb_idx_ff;
   logic [HISTORY_BITS-1:0]     pht_idx_ff;
   gbp_pkg::btb_entry_type      btb_rd_ff;
   logic [1:0]                  pht_rd_ff;

   logic [HISTORY_BITS-1:0]     hist_ff;
   logic [HISTORY_BITS-1:0]     hist_in;
   logic [HISTORY_BITS:0]       hist_cat;
   logic [CLR_BITS-1:0]         clr_ff;
   logic [CLR_BITS-1:0]         clr_in;

   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [gbp_pkg::ADDR_W-1:0]  rsp_next_pc_ff;
   logic                        rsp_btb_hit_ff;
   logic                        rsp_predict_taken_ff;

   logic [BTB_INDEX_BITS-1:0]   req_btb_idx;
   logic [HISTORY_BITS-1:0]     req_pht_idx;
   logic                        hit;
   logic                        redirect;
   logic [gbp_pkg::ADDR_W-1:0]  pc_plus4;
   logic [1:0]                  ctr_next;
   gbp_pkg::btb_entry_type      fill_entry;
   logic                        do_update;
   logic                        do_predict;

   always_comb begin
      req_btb_idx = req_pc[BTB_INDEX_BITS+1:2];
      req_pht_idx = hist_ff ^ req_pc[HISTORY_BITS+1:2];

      hit      = btb_rd_ff.valid && (btb_rd_ff.tag == pc_ff);
      redirect = hit && (!btb_rd_ff.cond || (pht_rd_ff >= gbp_pkg::CTR_TAKEN));
      pc_plus4 = pc_ff + gbp_pkg::PC_STEP;

      do_update  = cmd.finish && (cmd_ff == gbp_pkg::CMD_UPDATE);
      do_predict = cmd.finish && (cmd_ff == gbp_pkg::CMD_PREDICT);

      priority if (taken_ff && (pht_rd_ff != gbp_pkg::CTR_MAX)) begin
         ctr_next = pht_rd_ff + gbp_pkg::CTR_STEP;
      end else if (!taken_ff && (pht_rd_ff != gbp_pkg::CTR_MIN)) begin
         ctr_next = pht_rd_ff - gbp_pkg::CTR_STEP;
      end else begin
         ctr_next = pht_rd_ff;
      end

      fill_entry.valid  = 1'b1;
      fill_entry.cond   = is_cond_ff;
      fill_entry.tag    = pc_ff;
      fill_entry.target = (!is_cond_ff && !taken_ff) ? pc_plus4 : target_ff;

      hist_cat = {hist_ff, taken_ff};
      hist_in  = (do_update && is_cond_ff) ? hist_cat[HISTORY_BITS-1:0] : hist_ff;
      clr_in   = cmd.clear ? clr_ff + {{(CLR_BITS-1){1'b0}}, 1'b1} : clr_ff;

      if (do_predict) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      status.clear_last = (clr_ff == {CLR_BITS{1'b1}});
      status.is_update  = (cmd_ff == gbp_pkg::CMD_UPDATE);
      status.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hist_ff      <= hist_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmd_ff     <= req_cmd;
         pc_ff      <= req_pc;
         target_ff  <= req_target;
         taken_ff   <= req_taken;
         is_cond_ff <= req_is_cond;
         btb_idx_ff <= req_btb_idx;
         pht_idx_ff <= req_pht_idx;
      end
      if (do_predict) begin
         rsp_next_pc_ff       <= redirect ? btb_rd_ff.target : pc_plus4;
         rsp_btb_hit_ff       <= hit;
         rsp_predict_taken_ff <= redirect;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         btb_mem[clr_ff[BTB_INDEX_BITS-1:0]] <= '0;
         pht_mem[clr_ff[HISTORY_BITS-1:0]]   <= gbp_pkg::CTR_MIN;
      end else if (do_update) begin
         if (is_cond_ff) begin
            pht_mem[pht_idx_ff] <= ctr_next;
         end
         if (!hit) begin
            btb_mem[btb_idx_ff] <= fill_entry;
         end
      end
      if (cmd.accept) begin
         btb_rd_ff <= btb_mem[req_btb_idx];
         pht_rd_ff <= pht_mem[req_pht_idx];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_next_pc       = rsp_next_pc_ff;
   assign rsp_btb_hit       = rsp_btb_hit_ff;
   assign rsp_predict_taken = rsp_predict_taken_ff;

   a_predict_gives_beat: assert property (@(posedge clock) disable iff (reset)
      do_predict |=> rsp_valid_ff)
      else $error("predict finished without a result beat");

   a_redirect_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_predict_taken_ff |-> rsp_btb_hit_ff)
      else $error("redirect reported without a BTB hit");

   a_uncond_keeps_history: assert property (@(posedge clock) disable iff (reset)
      do_update && !is_cond_ff |=> $stable(hist_ff))
      else $error("unconditional update changed the history");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !cmd.accept && !cmd.finish)
      else $error("item handled during the clearing pass");

endmodule

@@ design/gshare_btb_branch_predictor.sv @@
// Each item has a registered BTB and counter read, then lookup and write-back.
// A predict result is held in the output register after its lookup; an update gives no result.
// A new item is accepted only once the previous one has finished; a predict waits in its
// lookup while a previous result is still held in the output register.
// Synchronous reset starts a clearing pass over the BTB valid bits and the counters,
// with req_ready low.
module gshare_btb_branch_predictor #(
   parameter int unsigned HISTORY_BITS   = 8,
   parameter int unsigned BTB_INDEX_BITS = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_cmd,
   input  logic [gbp_pkg::ADDR_W-1:0]  req_pc,
   input  logic [gbp_pkg::ADDR_W-1:0]  req_target,
   input  logic                        req_taken,
   input  logic                        req_is_cond,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [gbp_pkg::ADDR_W-1:0]  rsp_next_pc,
   output logic                        rsp_btb_hit,
   output logic                        rsp_predict_taken
);

   gbp_pkg::ctrl_cmd_type  cmd;
   gbp_pkg::dp_status_type status;

   gbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gbp_datapath #(
      .HISTORY_BITS   (HISTORY_BITS),
      .BTB_INDEX_BITS (BTB_INDEX_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_cmd           (req_cmd),
      .req_pc            (req_pc),
      .req_target        (req_target),
      .req_taken         (req_taken),
      .req_is_cond       (req_is_cond),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_next_pc       (rsp_next_pc),
      .rsp_btb_hit       (rsp_btb_hit),
      .rsp_predict_taken (rsp_predict_taken)
   );

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

localparam int HIST_BITS = 8;
localparam int SLOT_BITS = 10;

class fetch_scoreboard;
   typedef struct {
      bit [63:0] next_pc;
      bit        btb_hit;
      bit        redirect;
   } fetch_guess_type;

   bit [HIST_BITS-1:0] history;
   bit [1:0]           pattern_ctr [1 << HIST_BITS];
   bit [63:0]          slot_tag    [1 << SLOT_BITS];
   bit [63:0]          slot_target [1 << SLOT_BITS];
   bit                 slot_valid  [1 << SLOT_BITS];
   bit                 slot_cond   [1 << SLOT_BITS];
   fetch_guess_type    fetch_guesses[$];
   int                 mismatches;

   function int pending();
      return fetch_guesses.size();
   endfunction

   function void absorb_beat(bit cmd, bit [63:0] pc, bit [63:0] target, bit taken,
                             bit is_cond);
      bit [SLOT_BITS-1:0] slot;
      bit [HIST_BITS-1:0] pht;
      bit                 hit;
      bit [63:0]          fill;
      fetch_guess_type    guess;
      slot = pc[SLOT_BITS+1:2];
      pht  = history ^ pc[HIST_BITS+1:2];
      hit  = slot_valid[slot] && slot_tag[slot] == pc;
      if (cmd == gbp_pkg::CMD_PREDICT) begin
         guess.btb_hit  = hit;
         guess.redirect = hit && (!slot_cond[slot] || pattern_ctr[pht] >= gbp_pkg::CTR_TAKEN);
         guess.next_pc  = guess.redirect ? slot_target[slot] : pc + gbp_pkg::PC_STEP;
         fetch_guesses.push_back(guess);
         return;
      end
      if (is_cond) begin
         if (taken && pattern_ctr[pht] != gbp_pkg::CTR_MAX)
            pattern_ctr[pht] += gbp_pkg::CTR_STEP;
         else if (!taken && pattern_ctr[pht] != gbp_pkg::CTR_MIN)
            pattern_ctr[pht] -= gbp_pkg::CTR_STEP;
         history = {history[HIST_BITS-2:0], taken};
      end
      fill = (!is_cond && !taken) ? pc + gbp_pkg::PC_STEP : target;
      if (!hit) begin
         slot_tag[slot]    = pc;
         slot_target[slot] = fill;
         slot_valid[slot]  = 1'b1;
         slot_cond[slot]   = is_cond;
      end
   endfunction

   function void check_guess(logic [63:0] next_pc, logic btb_hit, logic redirect);
      fetch_guess_type guess;
      if (fetch_guesses.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected beat: next_pc %h hit %b taken %b", next_pc, btb_hit,
                     redirect);
         return;
      end
      guess = fetch_guesses.pop_front();
      if (next_pc !== guess.next_pc || btb_hit !== guess.btb_hit ||
          redirect !== guess.redirect) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: next_pc %h/%h hit %b/%b taken %b/%b (expected/actual)",
                     guess.next_pc, next_pc, guess.btb_hit, btb_hit, guess.redirect,
                     redirect);
      end
   endfunction
endclass

module testbench;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 400;
   localparam int POOL_SIZE    = 48;
   localparam int PHASE_BEATS  = 240;
   localparam int DRAIN_CYCLES = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_cmd = gbp_pkg::CMD_PREDICT;
   logic [63:0] req_pc = '0;
   logic [63:0] req_target = '0;
   logic        req_taken = 1'b0;
   logic        req_is_cond = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_next_pc;
   logic        rsp_btb_hit;
   logic        rsp_predict_taken;

   fetch_scoreboard fetch_sb = new();
   bit [63:0]       branch_pool [POOL_SIZE];
   int              idle_pct = 0;
   int              stall_pct = 0;
   bit              hold_request = 1'b0;
   int              hold_left = 0;
   int              cycle_count = 0;

   gshare_btb_branch_predictor u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_pc            (req_pc),
      .req_target        (req_target),
      .req_taken         (req_taken),
      .req_is_cond       (req_is_cond),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_next_pc       (rsp_next_pc),
      .rsp_btb_hit       (rsp_btb_hit),
      .rsp_predict_taken (rsp_predict_taken)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            fetch_sb.check_guess(rsp_next_pc, rsp_btb_hit, rsp_predict_taken);
         if (hold_request) begin
            hold_request <= 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send_beat(bit cmd, bit [63:0] pc, bit [63:0] target, bit taken,
                            bit is_cond);
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_pc      <= pc;
      req_target  <= target;
      req_taken   <= taken;
      req_is_cond <= is_cond;
      do @(posedge clock); while (!req_ready);
      fetch_sb.absorb_beat(cmd, pc, target, taken, is_cond);
   endtask

   task automatic random_beat();
      bit [63:0] pc;
      bit        cmd;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      pc  = ($urandom_range(99) < 75) ? branch_pool[$urandom_range(POOL_SIZE-1)]
                                      : {$urandom, $urandom};
      cmd = ($urandom_range(99) < 55) ? gbp_pkg::CMD_PREDICT : gbp_pkg::CMD_UPDATE;
      send_beat(cmd, pc, {$urandom, $urandom}, $urandom_range(99) < 60,
                $urandom_range(99) < 65);
   endtask

   task automatic directed_beats();
      bit [63:0] pc_a;
      bit [63:0] pc_b;
      bit [63:0] pc_wrap;
      pc_a    = 64'h0000_0000_0000_1000;
      pc_b    = 64'hA5A5_0000_0000_0123;
      pc_wrap = 64'hFFFF_FFFF_FFFF_FFFC;
      send_beat(gbp_pkg::CMD_PREDICT, '0, '1, 1'b1, 1'b1);
      send_beat(gbp_pkg::CMD_PREDICT, '1, '0, 1'b0, 1'b0);
      send_beat(gbp_pkg::CMD_UPDATE, pc_a, '1, 1'b1, 1'b0);
      send_beat(gbp_pkg::CMD_PREDICT, pc_a, '0, 1'b0, 1'b0);
      send_beat(gbp_pkg::CMD_UPDATE, pc_wrap, 64'h1234_5678_9ABC_DEF0, 1'b0, 1'b0);
      send_beat(gbp_pkg::CMD_PREDICT, pc_wrap, '0, 1'b0, 1'b0);
      send_beat(gbp_pkg::CMD_UPDATE, pc_a, 64'h5555_5555_5555_5555, 1'b0, 1'b1);
      send_beat(gbp_pkg::CMD_PREDICT, pc_a, '0, 1'b0, 1'b0);
      repeat (11) send_beat(gbp_pkg::CMD_UPDATE, pc_b, 64'hC3C3_C3C3_0000_FFFF, 1'b1, 1'b1);
      send_beat(gbp_pkg::CMD_PREDICT, pc_b, '0, 1'b0, 1'b0);
      send_beat(gbp_pkg::CMD_UPDATE, pc_b, '0, 1'b0, 1'b1);
      send_beat(gbp_pkg::CMD_UPDATE, pc_a + 64'h1000, 64'h0F0F_0F0F_0F0F_0F0F, 1'b1, 1'b0);
      send_beat(gbp_pkg::CMD_PREDICT, pc_a, '0, 1'b0, 1'b0);
      send_beat(gbp_pkg::CMD_PREDICT, pc_a + 64'h1000, '0, 1'b0, 1'b0);
   endtask

   initial begin
      for (int i = 0; i < POOL_SIZE; i++) begin
         if (i < 32)
            branch_pool[i] = {$urandom, $urandom};
         else
            branch_pool[i] = {$urandom, 20'($urandom_range(1048575)),
                              branch_pool[i-32][11:0]};
      end
      branch_pool[0] = 64'hFFFF_FFFF_FFFF_FFFC;
      branch_pool[1] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      directed_beats();
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct <= 0;  end
            1: begin idle_pct = 68; stall_pct <= 0;  end
            2: begin idle_pct = 0;  stall_pct <= 68; end
            default: begin idle_pct = 6; stall_pct <= 6; end
         endcase
         if (phase == 4)
            hold_request <= 1'b1;
         repeat (PHASE_BEATS) random_beat();
      end
      req_valid <= 1'b0;
      while (fetch_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fetch_sb.mismatches == 0 && fetch_sb.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
